/* rtl/kts_pkg.sv */
// kts_pkg: types, character codes, token kinds and the keyword table of the token scanner
// used by every module of the scanner; depends on nothing
`default_nettype none

package kts_pkg;

   localparam int KIND_W      = 6;
   localparam int START_W     = 32;
   localparam int LEN_W       = 16;
   localparam int LINE_W      = 24;
   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 4;

   // scanner modes
   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_INT,
      MODE_POINT,
      MODE_FRAC,
      MODE_MINUS,
      MODE_SLASH,
      MODE_STRING,
      MODE_COMMENT
   } scan_mode_type;

   // token kinds after the keywords
   localparam logic [KIND_W-1:0] KIND_NUMBER     = 6'd39;
   localparam logic [KIND_W-1:0] KIND_STRING     = 6'd40;
   localparam logic [KIND_W-1:0] KIND_IDENT      = 6'd41;
   localparam logic [KIND_W-1:0] KIND_PLUS       = 6'd42;
   localparam logic [KIND_W-1:0] KIND_MINUS      = 6'd43;
   localparam logic [KIND_W-1:0] KIND_AMP        = 6'd44;
   localparam logic [KIND_W-1:0] KIND_HASH       = 6'd45;
   localparam logic [KIND_W-1:0] KIND_DOT        = 6'd46;
   localparam logic [KIND_W-1:0] KIND_COMMA      = 6'd47;
   localparam logic [KIND_W-1:0] KIND_LPAREN     = 6'd48;
   localparam logic [KIND_W-1:0] KIND_RPAREN     = 6'd49;
   localparam logic [KIND_W-1:0] KIND_COMMENT    = 6'd50;
   localparam logic [KIND_W-1:0] KIND_NEWLINE    = 6'd51;
   localparam logic [KIND_W-1:0] KIND_EOF        = 6'd52;
   localparam logic [KIND_W-1:0] KIND_ERR_CHAR   = 6'd53;
   localparam logic [KIND_W-1:0] KIND_ERR_STRING = 6'd54;

   // character codes
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_POINT      = 8'h2E;
   localparam logic [7:0] CH_MINUS      = 8'h2D;
   localparam logic [7:0] CH_SLASH      = 8'h2F;
   localparam logic [7:0] CH_QUOTE      = 8'h22;
   localparam logic [7:0] CH_NEWLINE    = 8'h0A;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_PLUS       = 8'h2B;
   localparam logic [7:0] CH_AMP        = 8'h26;
   localparam logic [7:0] CH_HASH       = 8'h23;
   localparam logic [7:0] CH_COMMA      = 8'h2C;
   localparam logic [7:0] CH_LPAREN     = 8'h28;
   localparam logic [7:0] CH_RPAREN     = 8'h29;

   // keyword table, alphabetical, text right-justified
   localparam int NUM_KEYWORDS = 39;
   localparam int KW_TEXT_MAX  = 9;

   localparam logic [8*KW_TEXT_MAX-1:0] KW_TEXT [NUM_KEYWORDS] = '{
      "above", "and", "as", "at", "below", "block", "blueprint", "by",
      "calc", "can", "change", "create", "div", "each", "empty", "end",
      "erase", "fin", "finfr", "if", "in", "is", "make", "memo", "minus",
      "must", "not", "otherwise", "plus", "rem", "reply", "request", "set",
      "starts", "times", "to", "when", "within", "world"
   };

   localparam int KW_LEN [NUM_KEYWORDS] = '{
      5, 3, 2, 2, 5, 5, 9, 2, 4, 3, 6, 6, 3, 4, 5, 3, 5, 3, 5, 2, 2, 2, 4, 4,
      5, 4, 3, 9, 4, 3, 5, 7, 3, 6, 5, 2, 4, 6, 5
   };

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   length;
      logic [LINE_W-1:0]  line;
      logic               last;
   } token_type;

   // results of one request handed to the output queue
   typedef struct packed {
      logic [1:0]                        count;
      token_type [MAX_RESULTS-1:0]       tok;
   } push_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
             || (c == CH_UNDERSCORE);
   endfunction

   function automatic token_type mk_token(input logic [KIND_W-1:0]  kind,
                                          input logic [START_W-1:0] start,
                                          input logic [LEN_W-1:0]   length,
                                          input logic [LINE_W-1:0]  line);
      token_type t;
      t.kind   = kind;
      t.start  = start;
      t.length = length;
      t.line   = line;
      t.last   = 1'b0;
      return t;
   endfunction

endpackage

`default_nettype wire

/* rtl/keyword_token_scanner_core.sv */
// keyword_token_scanner_core: streaming lexer top level, input register, scanner and result queue
// depends on kts_pkg, kts_scan (with kts_kwmatch) and kts_outq
//
// usage
//   req_* carries one source byte per request, or an end-of-source marker
//   (req_end_of_source high, byte ignored) that flushes the pending token,
//   emits an EOF token and restarts offset and line counters
//   rsp_* carries tokens: kind, start offset, length, line and a flag on the
//   last token caused by a request; a request causes zero to three tokens
//   throughput: one request per cycle; the queue soaks up requests that
//   cause several tokens, and the input stalls only when more than one token
//   would remain queued after this cycle's pop
//   a taken request is held in the input register, then passes the scanner logic
//   into the four-entry result queue, whose head drives rsp_valid
//   rsp_stall only holds the queue; requests keep flowing until the queue
//   cannot take three more tokens, then req_stall rises
//   reset (synchronous) empties the queue and input register, puts the
//   scanner idle at offset zero, line one
`default_nettype none

module keyword_token_scanner_core
   import kts_pkg::*;
#(
   parameter int KEYWORD_MAX_LEN = 9,
   parameter int POSITION_BITS   = 32,
   parameter int LENGTH_BITS     = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic [7:0]         req_src_byte,
   input  wire logic               req_end_of_source,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [KIND_W-1:0]  rsp_token_kind,
   output      logic [START_W-1:0] rsp_token_start,
   output      logic [LEN_W-1:0]   rsp_token_length,
   output      logic [LINE_W-1:0]  rsp_token_line,
   output      logic               rsp_last_of_run
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] byte_ff;
   logic       eos_ff;

   logic       room;
   logic       fire;
   push_type   push;
   token_type  head;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

   // the held request proceeds when the queue can take its worst case
   assign fire      = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload loads only on an accepted request
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         byte_ff <= req_src_byte;
         eos_ff  <= req_end_of_source;
      end
   end

   kts_scan #(
      .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
      .POSITION_BITS   (POSITION_BITS),
      .LENGTH_BITS     (LENGTH_BITS)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .src_byte      (byte_ff),
      .end_of_source (eos_ff),
      .push          (push)
   );

   kts_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .head      (head),
      .room      (room),
      .count     (q_count)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_token_start  = head.start;
   assign rsp_token_length = head.length;
   assign rsp_token_line   = head.line;
   assign rsp_last_of_run  = head.last;

   // queue never holds more than its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
      else $error("result queue overflow");

   // nothing is pushed without a request going through
   a_push_needs_fire: assert property (@(posedge clock) disable iff (reset)
      !fire |-> push.count == 2'd0)
      else $error("tokens pushed without a request");

   // end of source always yields at least its EOF token
   a_eos_tokens: assert property (@(posedge clock) disable iff (reset)
      fire && eos_ff |-> push.count != 2'd0)
      else $error("end of source gave no token");

   // the last pushed token of a request carries the run flag
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |->
         (push.count == 2'd1 && push.tok[0].last) ||
         (push.count == 2'd2 && push.tok[1].last && !push.tok[0].last) ||
         (push.count == 2'd3 && push.tok[2].last && !push.tok[1].last))
      else $error("run flag misplaced");

endmodule

`default_nettype wire

/* rtl/kts_kwmatch.sv */
// kts_kwmatch: compares the buffered word against the keyword table
// depends on kts_pkg
`default_nettype none

module kts_kwmatch
   import kts_pkg::*;
#(
   parameter int KEYWORD_MAX_LEN = 9,
   parameter int LENGTH_BITS     = 16
) (
   input  wire logic [7:0]             chars [KEYWORD_MAX_LEN],
   input  wire logic                   too_long,
   input  wire logic [LENGTH_BITS-1:0] len,
   output      logic [KIND_W-1:0]      kind
);

   always_comb begin
      logic hit;
      kind = KIND_IDENT;
      hit  = 1'b0;
      if (!too_long && (len <= LENGTH_BITS'(KEYWORD_MAX_LEN))) begin
         for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
            hit = (len == LENGTH_BITS'(KW_LEN[k]));
            for (int i = 0; i < KW_TEXT_MAX; i++) begin
               if ((i < KW_LEN[k]) &&
                   (chars[i] != KW_TEXT[k][8*(KW_LEN[k]-1-i) +: 8])) begin
                  hit = 1'b0;
               end
            end
            if (hit) begin
               kind = KIND_W'(k);
            end
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/kts_scan.sv */
// kts_scan: scanner state and the per-byte token logic, up to three tokens per request
// depends on kts_pkg and kts_kwmatch
`default_nettype none

module kts_scan
   import kts_pkg::*;
#(
   parameter int KEYWORD_MAX_LEN = 9,
   parameter int POSITION_BITS   = 32,
   parameter int LENGTH_BITS     = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       fire,
   input  wire logic [7:0] src_byte,
   input  wire logic       end_of_source,
   output      push_type   push
);

   localparam logic [POSITION_BITS-1:0] POS_MAX  = '1;
   localparam logic [LENGTH_BITS-1:0]   LEN_MAX  = '1;
   localparam logic [LINE_W-1:0]        LINE_MAX = '1;

   scan_mode_type              mode_ff, mode_in;
   logic [7:0]                 chars_ff [KEYWORD_MAX_LEN];
   logic [7:0]                 chars_in [KEYWORD_MAX_LEN];
   logic                       too_long_ff, too_long_in;
   logic [POSITION_BITS-1:0]   start_ff, start_in;
   logic [LENGTH_BITS-1:0]     len_ff, len_in;
   logic [POSITION_BITS-1:0]   pos_ff, pos_in;
   logic [LINE_W-1:0]          line_ff, line_in;

   logic [KIND_W-1:0]          kw_kind;

   kts_kwmatch #(
      .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
      .LENGTH_BITS     (LENGTH_BITS)
   ) u_kwmatch (
      .chars    (chars_ff),
      .too_long (too_long_ff),
      .len      (len_ff),
      .kind     (kw_kind)
   );

   logic [LENGTH_BITS-1:0]   len_grow1, len_grow2;
   logic [LINE_W-1:0]        line_up;
   logic [POSITION_BITS-1:0] pos_prev;

   assign len_grow1 = (len_ff == LEN_MAX) ? len_ff : len_ff + 1'b1;
   assign len_grow2 = (len_grow1 == LEN_MAX) ? len_grow1 : len_grow1 + 1'b1;
   assign line_up   = (line_ff == LINE_MAX) ? line_ff : line_ff + 1'b1;
   assign pos_prev  = (pos_ff == '0) ? '0 : pos_ff - 1'b1;

   always_comb begin
      logic       brk;
      logic       fresh;
      logic       flush;
      logic       eof;
      logic       g_v;
      token_type  g_tok;
      token_type  f0_tok;
      token_type  f1_tok;
      logic       f0_v;
      logic       f1_v;
      token_type  cand   [4];
      logic       cand_v [4];
      logic [1:0] n;
      logic [LINE_W-1:0] fl_line;

      mode_in     = mode_ff;
      chars_in    = chars_ff;
      too_long_in = too_long_ff;
      start_in    = start_ff;
      len_in      = len_ff;
      pos_in      = pos_ff;
      line_in     = line_ff;
      brk         = 1'b0;
      fresh       = 1'b0;
      flush       = 1'b0;
      eof         = 1'b0;
      g_v         = 1'b0;
      g_tok       = '0;
      f0_v        = 1'b0;
      f1_v        = 1'b0;
      f0_tok      = '0;
      f1_tok      = '0;
      fl_line     = line_ff;
      push        = '0;
      n           = 2'd0;

      if (end_of_source) begin
         flush = 1'b1;
         eof   = 1'b1;
      end else begin
         pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
         case (mode_ff)
            MODE_IDENT: begin
               if (is_alpha(src_byte) || is_digit(src_byte)) begin
                  if (len_ff < LENGTH_BITS'(KEYWORD_MAX_LEN)) begin
                     for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
                        if (len_ff == LENGTH_BITS'(i)) begin
                           chars_in[i] = src_byte;
                        end
                     end
                  end else begin
                     too_long_in = 1'b1;
                  end
                  len_in = len_grow1;
               end else begin
                  brk = 1'b1;
               end
            end
            MODE_INT: begin
               if (is_digit(src_byte)) begin
                  len_in = len_grow1;
               end else if (src_byte == CH_POINT) begin
                  mode_in = MODE_POINT;
               end else begin
                  brk = 1'b1;
               end
            end
            MODE_POINT: begin
               if (is_digit(src_byte)) begin
                  len_in  = len_grow2;
                  mode_in = MODE_FRAC;
               end else begin
                  brk = 1'b1;
               end
            end
            MODE_FRAC: begin
               if (is_digit(src_byte)) begin
                  len_in = len_grow1;
               end else begin
                  brk = 1'b1;
               end
            end
            MODE_MINUS: begin
               if (is_digit(src_byte)) begin
                  len_in  = len_grow1;
                  mode_in = MODE_INT;
               end else begin
                  brk = 1'b1;
               end
            end
            MODE_SLASH: begin
               if (src_byte == CH_SLASH) begin
                  len_in  = len_grow1;
                  mode_in = MODE_COMMENT;
               end else begin
                  brk = 1'b1;
               end
            end
            MODE_STRING: begin
               len_in = len_grow1;
               if (src_byte == CH_QUOTE) begin
                  g_v     = 1'b1;
                  g_tok   = mk_token(KIND_STRING, START_W'(start_ff), LEN_W'(len_grow1),
                                     line_ff);
                  mode_in = MODE_IDLE;
               end else if (src_byte == CH_NEWLINE) begin
                  line_in = line_up;
               end
            end
            MODE_COMMENT: begin
               if (src_byte == CH_NEWLINE) begin
                  brk = 1'b1;
               end else begin
                  len_in = len_grow1;
               end
            end
            default: begin
               fresh = 1'b1;
            end
         endcase
         if (brk) begin
            flush = 1'b1;
            fresh = 1'b1;
         end
      end

      // tokens of the word left pending
      if (flush) begin
         case (mode_ff)
            MODE_IDENT: begin
               f0_v   = 1'b1;
               f0_tok = mk_token(kw_kind, START_W'(start_ff), LEN_W'(len_ff), fl_line);
            end
            MODE_INT, MODE_FRAC: begin
               f0_v   = 1'b1;
               f0_tok = mk_token(KIND_NUMBER, START_W'(start_ff), LEN_W'(len_ff), fl_line);
            end
            MODE_POINT: begin
               f0_v   = 1'b1;
               f0_tok = mk_token(KIND_NUMBER, START_W'(start_ff), LEN_W'(len_ff), fl_line);
               f1_v   = 1'b1;
               f1_tok = mk_token(KIND_DOT, START_W'(pos_prev), LEN_W'(1), fl_line);
            end
            MODE_MINUS: begin
               f0_v   = 1'b1;
               f0_tok = mk_token(KIND_MINUS, START_W'(start_ff), LEN_W'(1), fl_line);
            end
            MODE_SLASH: begin
               f0_v   = 1'b1;
               f0_tok = mk_token(KIND_ERR_CHAR, START_W'(start_ff), LEN_W'(1), fl_line);
            end
            MODE_STRING: begin
               f0_v   = 1'b1;
               f0_tok = mk_token(KIND_ERR_STRING, START_W'(start_ff), LEN_W'(len_ff),
                                 fl_line);
            end
            MODE_COMMENT: begin
               f0_v   = 1'b1;
               f0_tok = mk_token(KIND_COMMENT, START_W'(start_ff), LEN_W'(len_ff), fl_line);
            end
            default: begin
            end
         endcase
      end

      // current byte scanned from the idle state
      if (fresh) begin
         mode_in = MODE_IDLE;
         if (is_digit(src_byte)) begin
            mode_in  = MODE_INT;
            start_in = pos_ff;
            len_in   = LENGTH_BITS'(1);
         end else if (is_alpha(src_byte)) begin
            mode_in     = MODE_IDENT;
            start_in    = pos_ff;
            len_in      = LENGTH_BITS'(1);
            chars_in[0] = src_byte;
            too_long_in = 1'b0;
         end else begin
            case (src_byte)
               CH_SPACE, CH_TAB, CH_CR: begin
               end
               CH_NEWLINE: begin
                  line_in = line_up;
                  g_v     = 1'b1;
                  g_tok   = mk_token(KIND_NEWLINE, START_W'(pos_ff), LEN_W'(1), line_up);
               end
               CH_PLUS: begin
                  g_v   = 1'b1;
                  g_tok = mk_token(KIND_PLUS, START_W'(pos_ff), LEN_W'(1), line_ff);
               end
               CH_AMP: begin
                  g_v   = 1'b1;
                  g_tok = mk_token(KIND_AMP, START_W'(pos_ff), LEN_W'(1), line_ff);
               end
               CH_HASH: begin
                  g_v   = 1'b1;
                  g_tok = mk_token(KIND_HASH, START_W'(pos_ff), LEN_W'(1), line_ff);
               end
               CH_POINT: begin
                  g_v   = 1'b1;
                  g_tok = mk_token(KIND_DOT, START_W'(pos_ff), LEN_W'(1), line_ff);
               end
               CH_COMMA: begin
                  g_v   = 1'b1;
                  g_tok = mk_token(KIND_COMMA, START_W'(pos_ff), LEN_W'(1), line_ff);
               end
               CH_LPAREN: begin
                  g_v   = 1'b1;
                  g_tok = mk_token(KIND_LPAREN, START_W'(pos_ff), LEN_W'(1), line_ff);
               end
               CH_RPAREN: begin
                  g_v   = 1'b1;
                  g_tok = mk_token(KIND_RPAREN, START_W'(pos_ff), LEN_W'(1), line_ff);
               end
               CH_MINUS: begin
                  mode_in  = MODE_MINUS;
                  start_in = pos_ff;
                  len_in   = LENGTH_BITS'(1);
               end
               CH_SLASH: begin
                  mode_in  = MODE_SLASH;
                  start_in = pos_ff;
                  len_in   = LENGTH_BITS'(1);
               end
               CH_QUOTE: begin
                  mode_in  = MODE_STRING;
                  start_in = pos_ff;
                  len_in   = LENGTH_BITS'(1);
               end
               default: begin
                  g_v   = 1'b1;
                  g_tok = mk_token(KIND_ERR_CHAR, START_W'(pos_ff), LEN_W'(1), line_ff);
               end
            endcase
         end
      end

      // end of source restarts mode, start, length, offset and line counters
      if (eof) begin
         mode_in     = MODE_IDLE;
         too_long_in = 1'b0;
         start_in    = '0;
         len_in      = '0;
         pos_in      = '0;
         line_in     = LINE_W'(1);
      end

      // pack in emission order
      cand[0]   = f0_tok;
      cand_v[0] = f0_v;
      cand[1]   = f1_tok;
      cand_v[1] = f1_v;
      cand[2]   = g_tok;
      cand_v[2] = g_v;
      cand[3]   = mk_token(KIND_EOF, START_W'(pos_ff), LEN_W'(0), line_ff);
      cand_v[3] = eof;
      for (int j = 0; j < 4; j++) begin
         if (cand_v[j] && (n != 2'd3)) begin
            push.tok[n] = cand[j];
            n           = n + 2'd1;
         end
      end
      if (n != 2'd0) begin
         push.tok[n - 2'd1].last = 1'b1;
      end
      push.count = fire ? n : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         too_long_ff <= 1'b0;
         start_ff    <= '0;
         len_ff      <= '0;
         pos_ff      <= '0;
         line_ff     <= LINE_W'(1);
      end else if (fire) begin
         mode_ff     <= mode_in;
         too_long_ff <= too_long_in;
         start_ff    <= start_in;
         len_ff      <= len_in;
         pos_ff      <= pos_in;
         line_ff     <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         chars_ff <= chars_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/kts_outq.sv */
// kts_outq: short shifting result queue, takes up to three tokens a cycle, gives one
// when out_stall is low; depends on kts_pkg
`default_nettype none

module kts_outq
   import kts_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire push_type  push,
   input  wire logic      out_stall,
   output      logic      out_valid,
   output      token_type head,
   output      logic      room,
   output      logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   token_type        q_ff [QUEUE_DEPTH];
   token_type        q_in [QUEUE_DEPTH];
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pop;
   logic [CNT_W-1:0] base;

   assign pop       = (cnt_ff != '0) && !out_stall;
   assign base      = cnt_ff - CNT_W'(pop);
   assign room      = (base <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS));
   assign out_valid = (cnt_ff != '0);
   assign head      = q_ff[0];
   assign count     = cnt_ff;
   assign cnt_in    = base + CNT_W'(push.count);

   always_comb begin
      logic [CNT_W-1:0] off;
      off  = '0;
      q_in = q_ff;
      if (pop) begin
         for (int e = 0; e < QUEUE_DEPTH - 1; e++) begin
            q_in[e] = q_ff[e + 1];
         end
      end
      for (int e = 0; e < QUEUE_DEPTH; e++) begin
         off = CNT_W'(e) - base;
         if ((CNT_W'(e) >= base) && (off < CNT_W'(push.count))) begin
            q_in[e] = push.tok[off[1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

endmodule

`default_nettype wire
